>>> src/sdt_pkg.sv
// Shared types and constants for the sphere-triangle distance unit.
`timescale 1ns / 1ps
package sdt_pkg;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_CENTER_Z = 2'd2;
  localparam logic [1:0] REG_RADIUS   = 2'd3;

  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 32;

  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] T_ONE    = 31'h4000_0000;

  typedef struct packed {
    logic [2:0][31:0] s;
    logic [2:0][32:0] d;
  } seg_t;

  typedef struct packed {
    seg_t [2:0]       seg;
    logic             in_tri;
    logic [30:0]      idist;
    logic [2:0][31:0] osat;
  } div_side_t;

  typedef struct packed {
    logic             use_root;
    logic             in_tri;
    logic             no_hit;
    logic [30:0]      dist_v;
    logic [2:0][31:0] res;
  } root_side_t;

  function automatic logic [31:0] sat32(input logic signed [38:0] x);
    logic [31:0] r;
    if (x > 39'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -39'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/sdt_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage.
`timescale 1ns / 1ps
module sdt_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  sdt_pkg::div_side_t       side_i,
  input  logic [2:0][65:0]         mu_i,
  input  logic [2:0][65:0]         len2_i,
  input  logic [2:0]               hold_i,
  input  logic [2:0][30:0]         t_i,
  output logic                     vld_o,
  output sdt_pkg::div_side_t       side_o,
  output logic [2:0][30:0]         t_o
);
  import sdt_pkg::*;

  logic [DIV_STEPS-1:0] vld_q;
  div_side_t            side_q [DIV_STEPS];
  logic [2:0][65:0]     rem_q  [DIV_STEPS];
  logic [2:0][65:0]     len_q  [DIV_STEPS];
  logic [2:0]           hold_q [DIV_STEPS];
  logic [2:0][30:0]     t_q    [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_stage
    logic             vld_in;
    div_side_t        side_in;
    logic [2:0][65:0] rem_in, len_in, rem_d;
    logic [2:0]       hold_in;
    logic [2:0][30:0] t_in, t_d;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign side_in = side_i;
      assign rem_in  = mu_i;
      assign len_in  = len2_i;
      assign hold_in = hold_i;
      assign t_in    = t_i;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign side_in = side_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign len_in  = len_q[g-1];
      assign hold_in = hold_q[g-1];
      assign t_in    = t_q[g-1];
    end

    always_comb begin
      logic [66:0] sh;
      logic        ge;
      for (int l = 0; l < 3; l++) begin
        sh = {rem_in[l], 1'b0};
        ge = (sh >= {1'b0, len_in[l]});
        rem_d[l] = ge ? 66'(sh - {1'b0, len_in[l]}) : sh[65:0];
        t_d[l]   = hold_in[l] ? t_in[l] : {t_in[l][29:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g] <= side_in;
        rem_q[g]  <= rem_d;
        len_q[g]  <= len_in;
        hold_q[g] <= hold_in;
        t_q[g]    <= t_d;
      end
    end
  end

  assign vld_o  = vld_q[DIV_STEPS-1];
  assign side_o = side_q[DIV_STEPS-1];
  assign t_o    = t_q[DIV_STEPS-1];

endmodule

>>> src/sdt_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module sdt_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  sdt_pkg::root_side_t side_i,
  input  logic [63:0]         val_i,
  output logic                vld_o,
  output sdt_pkg::root_side_t side_o,
  output logic [30:0]         root_o
);
  import sdt_pkg::*;

  logic [SQRT_STEPS-1:0] vld_q;
  root_side_t            side_q [SQRT_STEPS];
  logic [63:0]           v_q    [SQRT_STEPS];
  logic [63:0]           r_q    [SQRT_STEPS];

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic        vld_in;
    root_side_t  side_in;
    logic [63:0] v_in, r_in, v_d, r_d;

    if (g == 0) begin : g_first
      assign vld_in  = vld_i;
      assign side_in = side_i;
      assign v_in    = val_i;
      assign r_in    = '0;
    end else begin : g_next
      assign vld_in  = vld_q[g-1];
      assign side_in = side_q[g-1];
      assign v_in    = v_q[g-1];
      assign r_in    = r_q[g-1];
    end

    always_comb begin
      logic [63:0] trial;
      trial = r_in + BIT;
      if (v_in >= trial) begin
        v_d = v_in - trial;
        r_d = (r_in >> 1) + BIT;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g] <= side_in;
        v_q[g]    <= v_d;
        r_q[g]    <= r_d;
      end
    end
  end

  assign vld_o  = vld_q[SQRT_STEPS-1];
  assign side_o = side_q[SQRT_STEPS-1];
  assign root_o = r_q[SQRT_STEPS-1][30:0];

endmodule

>>> src/sphere_triangle_distance_unit.sv
// Top level: sphere versus triangle closest-point distance pipeline.
//
// One triangle (three Q16.16 vertices, Q2.14 unit normal) enters on the input
// channel when in_valid_i and in_ready_o are both high. One result beat leaves
// per triangle on the output channel (out_valid_o / out_ready_i), in order.
// The sphere center and radius are written through cfg_we_i / cfg_idx_i /
// cfg_data_i while no triangle is in flight; the user must ensure this.
// The pipeline has 7 setup stages (plane offset, projection, crossing
// and edge products), 30 divider stages for the edge parameter, 5 stages for
// edge point, squared distance and selection, 32 square-root stages and the
// output register. Throughput is one triangle per cycle unless the output holds.
// The whole pipeline advances together; it holds when a result waits at the
// output and the receiver is not ready, and bubbles drain while the output is
// empty. Reset empties the pipeline and sets center 0 and radius 1.0.
`timescale 1ns / 1ps
module sphere_triangle_distance_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] a_x_i,
  input  logic signed [31:0] a_y_i,
  input  logic signed [31:0] a_z_i,
  input  logic signed [31:0] b_x_i,
  input  logic signed [31:0] b_y_i,
  input  logic signed [31:0] b_z_i,
  input  logic signed [31:0] c_x_i,
  input  logic signed [31:0] c_y_i,
  input  logic signed [31:0] c_z_i,
  input  logic signed [15:0] norm_x_i,
  input  logic signed [15:0] norm_y_i,
  input  logic signed [15:0] norm_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        distance_o,
  output logic signed [31:0] offset_x_o,
  output logic signed [31:0] offset_y_o,
  output logic signed [31:0] offset_z_o,
  output logic               inside_res_o,
  output logic               no_hit_o
);
  import sdt_pkg::*;

  logic               en;
  logic signed [31:0] cen_q [3];
  logic [30:0]        rad_q;
  logic [61:0]        rsq_q;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
      rad_q    <= 31'd65536;
      rsq_q    <= 62'd4294967296;
    end else begin
      rsq_q <= rad_q * rad_q;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER_X: cen_q[0] <= cfg_data_i;
          REG_CENTER_Y: cen_q[1] <= cfg_data_i;
          REG_CENTER_Z: cen_q[2] <= cfg_data_i;
          REG_RADIUS:   rad_q    <= cfg_data_i[30:0];
          default:      rad_q    <= rad_q;
        endcase
      end
    end
  end

  // ---------------- stage 1: plane offset products, axis pick
  logic signed [31:0] vin [3][3];
  logic signed [15:0] nin [3];
  logic signed [31:0] v1_q [3][3];
  logic signed [15:0] n1_q [3];
  logic signed [48:0] pr1_d [3], pr1_q [3];
  logic [1:0]         cu1_d, cv1_d, cu1_q, cv1_q;

  assign vin[0][0] = a_x_i; assign vin[0][1] = a_y_i; assign vin[0][2] = a_z_i;
  assign vin[1][0] = b_x_i; assign vin[1][1] = b_y_i; assign vin[1][2] = b_z_i;
  assign vin[2][0] = c_x_i; assign vin[2][1] = c_y_i; assign vin[2][2] = c_z_i;
  assign nin[0] = norm_x_i; assign nin[1] = norm_y_i; assign nin[2] = norm_z_i;

  always_comb begin
    logic signed [32:0] sub;
    logic [16:0]        ax, ay, az;
    for (int k = 0; k < 3; k++) begin
      sub      = vin[0][k] - cen_q[k];
      pr1_d[k] = nin[k] * sub;
    end
    ax = norm_x_i[15] ? 17'd0 - {1'b1, norm_x_i} : {1'b0, norm_x_i};
    ay = norm_y_i[15] ? 17'd0 - {1'b1, norm_y_i} : {1'b0, norm_y_i};
    az = norm_z_i[15] ? 17'd0 - {1'b1, norm_z_i} : {1'b0, norm_z_i};
    if (az > ay) begin
      cu1_d = 2'd1;
      cv1_d = (az > ax) ? 2'd0 : 2'd2;
    end else if (ay > ax) begin
      cu1_d = 2'd2;
      cv1_d = 2'd0;
    end else begin
      cu1_d = 2'd1;
      cv1_d = 2'd2;
    end
  end

  // ---------------- stage 2: plane offset d16
  logic signed [31:0] v2_q [3][3];
  logic signed [15:0] n2_q [3];
  logic signed [36:0] d16_2_d, d16_2_q;
  logic [1:0]         cu2_q, cv2_q;

  always_comb begin
    logic signed [50:0] dsum;
    dsum    = pr1_q[0] + pr1_q[1] + pr1_q[2] + 51'sd8192;
    d16_2_d = dsum[50:14];
  end

  // ---------------- stage 3: projection products
  logic signed [31:0] v3_q [3][3];
  logic signed [52:0] pr3_q [3];
  logic signed [36:0] d16_3_q;
  logic [1:0]         cu3_q, cv3_q;

  // ---------------- stage 4: offset and projected point
  logic signed [31:0] v4_q [3][3];
  logic signed [38:0] off4_d [3], off4_q [3];
  logic signed [39:0] p4_d [3], p4_q [3];
  logic signed [36:0] d16_4_q;
  logic [1:0]         cu4_q, cv4_q;

  always_comb begin
    logic signed [52:0] rnd;
    for (int k = 0; k < 3; k++) begin
      rnd       = pr3_q[k] + 53'sd8192;
      off4_d[k] = rnd[52:14];
      p4_d[k]   = cen_q[k] + off4_d[k];
    end
  end

  // ---------------- stage 5: crossing and edge products
  logic signed [31:0] v5_q [3][3];
  logic signed [38:0] off5_q [3];
  logic signed [36:0] d16_5_q;
  logic               rng5_d [3], rng5_q [3], dup5_d [3], dup5_q [3];
  logic signed [73:0] m1_5_d [3], m1_5_q [3], m2_5_d [3], m2_5_q [3];
  logic signed [73:0] mup5_d [3][3], mup5_q [3][3];
  logic signed [65:0] lsq5_d [3][3], lsq5_q [3][3];
  logic signed [32:0] dd5_d [3][3], dd5_q [3][3];

  always_comb begin
    logic signed [39:0] pu, pv;
    logic signed [31:0] ui, vi, uj, vj;
    logic signed [40:0] a1, a2, ps;
    logic signed [32:0] b1, b2;
    int j, nx;
    pu = p4_q[cu4_q];
    pv = p4_q[cv4_q];
    for (int i = 0; i < 3; i++) begin
      j  = (i == 0) ? 2 : i - 1;
      nx = (i == 2) ? 0 : i + 1;
      ui = v4_q[i][cu4_q];
      vi = v4_q[i][cv4_q];
      uj = v4_q[j][cu4_q];
      vj = v4_q[j][cv4_q];
      rng5_d[i] = (ui <= pu && pu < uj) || (uj <= pu && pu < ui);
      dup5_d[i] = uj > ui;
      a1 = pu - ui;
      b1 = vj - vi;
      a2 = pv - vi;
      b2 = uj - ui;
      m1_5_d[i] = a1 * b1;
      m2_5_d[i] = a2 * b2;
      for (int k = 0; k < 3; k++) begin
        dd5_d[i][k]  = v4_q[nx][k] - v4_q[i][k];
        ps           = p4_q[k] - v4_q[i][k];
        mup5_d[i][k] = ps * dd5_d[i][k];
        lsq5_d[i][k] = dd5_d[i][k] * dd5_d[i][k];
      end
    end
  end

  // ---------------- stage 6: sums and crossing decisions
  logic signed [31:0] v6_q [3][3];
  logic signed [32:0] dd6_q [3][3];
  logic signed [38:0] off6_q [3];
  logic signed [36:0] d16_6_q;
  logic [2:0]         crs6_d, crs6_q;
  logic signed [75:0] mu6_d [3], mu6_q [3];
  logic [65:0]        len6_d [3], len6_q [3];

  always_comb begin
    logic signed [74:0] diff;
    logic signed [66:0] ls;
    for (int i = 0; i < 3; i++) begin
      diff      = m1_5_q[i] - m2_5_q[i];
      crs6_d[i] = rng5_q[i] && (dup5_q[i] ? (diff > 75'sd0) : (diff < 75'sd0));
      mu6_d[i]  = mup5_q[i][0] + mup5_q[i][1] + mup5_q[i][2];
      ls        = lsq5_q[i][0] + lsq5_q[i][1] + lsq5_q[i][2];
      len6_d[i] = ls[65:0];
    end
  end

  // ---------------- stage 7: clamp class, inside results
  logic               vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q;
  div_side_t          side7_d, side7_q;
  logic [2:0][65:0]   mu7_d, mu7_q, len7_d, len7_q;
  logic [2:0]         hold7_d, hold7_q;
  logic [2:0][30:0]   t7_d, t7_q;

  always_comb begin
    logic        nonpos, ge;
    logic [37:0] dm;
    for (int i = 0; i < 3; i++) begin
      nonpos     = mu6_q[i] <= 76'sd0;
      ge         = mu6_q[i] >= $signed({10'd0, len6_q[i]});
      hold7_d[i] = nonpos || ge;
      t7_d[i]    = (ge && !nonpos) ? T_ONE : '0;
      mu7_d[i]   = mu6_q[i][65:0];
      len7_d[i]  = len6_q[i];
      for (int k = 0; k < 3; k++) begin
        side7_d.seg[i].s[k] = v6_q[i][k];
        side7_d.seg[i].d[k] = dd6_q[i][k];
      end
    end
    side7_d.in_tri = ^crs6_q;
    dm = d16_6_q[36] ? 38'd0 - {1'b1, d16_6_q} : {1'b0, d16_6_q};
    side7_d.idist = (dm > {7'd0, DIST_MAX}) ? DIST_MAX : dm[30:0];
    for (int k = 0; k < 3; k++) begin
      side7_d.osat[k] = sat32(off6_q[k]);
    end
  end

  logic             vld_dv;
  div_side_t        side_dv;
  logic [2:0][30:0] t_dv;

  sdt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld7_q),
    .side_i (side7_q),
    .mu_i   (mu7_q),
    .len2_i (len7_q),
    .hold_i (hold7_q),
    .t_i    (t7_q),
    .vld_o  (vld_dv),
    .side_o (side_dv),
    .t_o    (t_dv)
  );

  // ---------------- stage 8: t * edge
  logic               vld8_q, vld9_q, vld10_q, vld11_q, vld12_q;
  div_side_t          side8_q, side9_q, side10_q, side11_q;
  logic signed [63:0] pt8_d [3][3], pt8_q [3][3];

  always_comb begin
    logic signed [31:0] tt;
    for (int i = 0; i < 3; i++) begin
      tt = {1'b0, t_dv[i]};
      for (int k = 0; k < 3; k++) begin
        pt8_d[i][k] = tt * $signed(side_dv.seg[i].d[k]);
      end
    end
  end

  // ---------------- stage 9: edge point, offset, radius box test
  logic [31:0] tmp9_d [3][3], tmp9_q [3][3], tmp10_q [3][3], tmp11_q [3][3];
  logic [30:0] mag9_d [3][3], mag9_q [3][3];
  logic [2:0]  ok9_d, ok9_q, ok10_q;

  always_comb begin
    logic signed [63:0] rnd;
    logic signed [34:0] q;
    logic signed [35:0] tm;
    logic [35:0]        mg;
    for (int i = 0; i < 3; i++) begin
      ok9_d[i] = 1'b1;
      for (int k = 0; k < 3; k++) begin
        rnd = pt8_q[i][k] + 64'sd536870912;
        q   = $signed(side8_q.seg[i].s[k]) + $signed(rnd[63:30]);
        tm  = q - cen_q[k];
        mg  = tm[35] ? 36'd0 - tm : tm;
        if (mg >= {5'd0, rad_q}) begin
          ok9_d[i] = 1'b0;
        end
        tmp9_d[i][k] = tm[31:0];
        mag9_d[i][k] = mg[30:0];
      end
    end
  end

  // ---------------- stage 10: squares
  logic [61:0] sq10_q [3][3];

  // ---------------- stage 11: squared distance, radius test
  logic [63:0] sum11_d [3], sum11_q [3];
  logic [2:0]  qual11_d, qual11_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum11_d[i]  = 64'(sq10_q[i][0]) + 64'(sq10_q[i][1]) + 64'(sq10_q[i][2]);
      qual11_d[i] = ok10_q[i] && (sum11_d[i] < {2'd0, rsq_q});
    end
  end

  // ---------------- stage 12: nearest edge pick
  root_side_t  side12_d, side12_q;
  logic [63:0] val12_d, val12_q;

  always_comb begin
    logic             found;
    logic [63:0]      best;
    logic [2:0][31:0] rs;
    found = 1'b0;
    best  = '0;
    rs    = '0;
    for (int i = 0; i < 3; i++) begin
      if (qual11_q[i] && (!found || sum11_q[i] < best)) begin
        found = 1'b1;
        best  = sum11_q[i];
        for (int k = 0; k < 3; k++) begin
          rs[k] = tmp11_q[i][k];
        end
      end
    end
    side12_d.in_tri   = side11_q.in_tri;
    side12_d.use_root = !side11_q.in_tri && found;
    side12_d.no_hit   = !side11_q.in_tri && !found;
    side12_d.dist_v   = side11_q.in_tri ? side11_q.idist : DIST_MAX;
    side12_d.res      = side12_d.use_root ? rs : side11_q.osat;
    val12_d           = side12_d.use_root ? best : '0;
  end

  logic        vld_rt;
  root_side_t  side_rt;
  logic [30:0] root_rt;

  sdt_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld12_q),
    .side_i (side12_q),
    .val_i  (val12_q),
    .vld_o  (vld_rt),
    .side_o (side_rt),
    .root_o (root_rt)
  );

  // ---------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      vld3_q      <= 1'b0;
      vld4_q      <= 1'b0;
      vld5_q      <= 1'b0;
      vld6_q      <= 1'b0;
      vld7_q      <= 1'b0;
      vld8_q      <= 1'b0;
      vld9_q      <= 1'b0;
      vld10_q     <= 1'b0;
      vld11_q     <= 1'b0;
      vld12_q     <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      vld1_q      <= in_valid_i;
      vld2_q      <= vld1_q;
      vld3_q      <= vld2_q;
      vld4_q      <= vld3_q;
      vld5_q      <= vld4_q;
      vld6_q      <= vld5_q;
      vld7_q      <= vld6_q;
      vld8_q      <= vld_dv;
      vld9_q      <= vld8_q;
      vld10_q     <= vld9_q;
      vld11_q     <= vld10_q;
      vld12_q     <= vld11_q;
      out_valid_o <= vld_rt;
    end
  end

  // ---------------- payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      v1_q    <= vin;
      n1_q    <= nin;
      pr1_q   <= pr1_d;
      cu1_q   <= cu1_d;
      cv1_q   <= cv1_d;

      v2_q    <= v1_q;
      n2_q    <= n1_q;
      d16_2_q <= d16_2_d;
      cu2_q   <= cu1_q;
      cv2_q   <= cv1_q;

      v3_q    <= v2_q;
      for (int k = 0; k < 3; k++) begin
        pr3_q[k] <= n2_q[k] * d16_2_q;
      end
      d16_3_q <= d16_2_q;
      cu3_q   <= cu2_q;
      cv3_q   <= cv2_q;

      v4_q    <= v3_q;
      off4_q  <= off4_d;
      p4_q    <= p4_d;
      d16_4_q <= d16_3_q;
      cu4_q   <= cu3_q;
      cv4_q   <= cv3_q;

      v5_q    <= v4_q;
      off5_q  <= off4_q;
      d16_5_q <= d16_4_q;
      rng5_q  <= rng5_d;
      dup5_q  <= dup5_d;
      m1_5_q  <= m1_5_d;
      m2_5_q  <= m2_5_d;
      mup5_q  <= mup5_d;
      lsq5_q  <= lsq5_d;
      dd5_q   <= dd5_d;

      v6_q    <= v5_q;
      dd6_q   <= dd5_q;
      off6_q  <= off5_q;
      d16_6_q <= d16_5_q;
      crs6_q  <= crs6_d;
      mu6_q   <= mu6_d;
      len6_q  <= len6_d;

      side7_q <= side7_d;
      mu7_q   <= mu7_d;
      len7_q  <= len7_d;
      hold7_q <= hold7_d;
      t7_q    <= t7_d;

      side8_q <= side_dv;
      pt8_q   <= pt8_d;

      side9_q <= side8_q;
      tmp9_q  <= tmp9_d;
      mag9_q  <= mag9_d;
      ok9_q   <= ok9_d;

      side10_q <= side9_q;
      tmp10_q  <= tmp9_q;
      ok10_q   <= ok9_q;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          sq10_q[i][k] <= mag9_q[i][k] * mag9_q[i][k];
        end
      end

      side11_q <= side10_q;
      tmp11_q  <= tmp10_q;
      sum11_q  <= sum11_d;
      qual11_q <= qual11_d;

      side12_q <= side12_d;
      val12_q  <= val12_d;

      distance_o   <= side_rt.use_root ? root_rt : side_rt.dist_v;
      offset_x_o   <= side_rt.res[0];
      offset_y_o   <= side_rt.res[1];
      offset_z_o   <= side_rt.res[2];
      inside_res_o <= side_rt.in_tri;
      no_hit_o     <= side_rt.no_hit;
    end
  end

endmodule

>>> test/sdt_result_checker.sv
// Result checker for the sphere-triangle distance unit: predicts each result and compares.
`timescale 1ns / 1ps
module sdt_result_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] vtx_i [9],
  input  logic signed [15:0] nrm_i [3],
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [30:0]        distance_i,
  input  logic [31:0]        offset_x_i,
  input  logic [31:0]        offset_y_i,
  input  logic [31:0]        offset_z_i,
  input  logic               inside_res_i,
  input  logic               no_hit_i,
  output int                 errors_o,
  output int                 pending_o
);
  import sdt_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [30:0]      dist_v;
    logic [2:0][31:0] offs;
    logic             in_tri;
    logic             no_hit;
  } hit_t;

  hit_t              hit_q [$];
  logic signed [31:0] sphere_c [3];
  logic [30:0]        sphere_r;

  function automatic wide_t rnd_shr(input wide_t x, input int k);
    return (x + (wide_t'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic wide_t absw(input wide_t x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic wide_t clip32(input wide_t x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit edge_crosses(input wide_t pu, input wide_t pv, input wide_t ui,
                                      input wide_t vi, input wide_t uj, input wide_t vj);
    wide_t du;
    wide_t diff;
    du = uj - ui;
    if (!((ui <= pu && pu < uj) || (uj <= pu && pu < ui))) return 0;
    diff = (pu - ui) * (vj - vi) - (pv - vi) * du;
    if (du > 0) return diff > 0;
    return diff < 0;
  endfunction

  function automatic void clamp_to_edge(input wide_t p [3], input wide_t s [3],
                                        input wide_t e [3], output wide_t q [3]);
    wide_t dv [3];
    wide_t mu;
    wide_t len2;
    wide_t t;
    mu = 0;
    len2 = 0;
    for (int k = 0; k < 3; k++) begin
      dv[k] = e[k] - s[k];
      mu += (p[k] - s[k]) * dv[k];
      len2 += dv[k] * dv[k];
    end
    if (mu <= 0) begin
      q = s;
    end else if (mu >= len2) begin
      q = e;
    end else begin
      t = (mu <<< 30) / len2;
      for (int k = 0; k < 3; k++) q[k] = s[k] + rnd_shr(t * dv[k], 30);
    end
  endfunction

  function automatic hit_t predict_hit(input logic signed [31:0] vt [9],
                                       input logic signed [15:0] nr [3]);
    wide_t v [3][3];
    wide_t s [3];
    wide_t e [3];
    wide_t n [3];
    wide_t c [3];
    wide_t off [3];
    wide_t p [3];
    wide_t q [3];
    wide_t tmp [3];
    wide_t res [3];
    wide_t d;
    wide_t d16;
    wide_t best;
    wide_t sum;
    wide_t rad;
    wide_t ax;
    wide_t ay;
    wide_t az;
    logic [63:0] rt;
    int    cu;
    int    cv;
    bit    in_tri;
    bit    found;
    bit    ok;
    hit_t  h;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) v[i][k] = vt[i * 3 + k];
    for (int k = 0; k < 3; k++) begin
      n[k] = nr[k];
      c[k] = sphere_c[k];
    end
    rad = {97'd0, sphere_r};
    d = 0;
    for (int k = 0; k < 3; k++) d += n[k] * (v[0][k] - c[k]);
    d16 = rnd_shr(d, 14);
    for (int k = 0; k < 3; k++) begin
      off[k] = rnd_shr(n[k] * d16, 14);
      p[k] = c[k] + off[k];
    end
    ax = absw(n[0]);
    ay = absw(n[1]);
    az = absw(n[2]);
    if (az > ay && az > ax) begin
      cu = 1; cv = 0;
    end else if (az <= ay && ay > ax) begin
      cu = 2; cv = 0;
    end else begin
      cu = 1; cv = 2;
    end
    in_tri = 0;
    for (int i = 0; i < 3; i++) begin
      int j;
      j = (i == 0) ? 2 : i - 1;
      if (edge_crosses(p[cu], p[cv], v[i][cu], v[i][cv], v[j][cu], v[j][cv]))
        in_tri = !in_tri;
    end
    found = 0;
    best = 0;
    h.in_tri = in_tri;
    h.no_hit = 0;
    if (in_tri) begin
      best = absw(d16);
      h.dist_v = (best > 64'sh7FFFFFFF) ? DIST_MAX : best[30:0];
      for (int k = 0; k < 3; k++) res[k] = clip32(off[k]);
    end else begin
      for (int i = 0; i < 3; i++) begin
        s = v[i];
        e = v[(i + 1) % 3];
        clamp_to_edge(p, s, e, q);
        ok = 1;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
          tmp[k] = q[k] - c[k];
          if (absw(tmp[k]) >= rad) ok = 0;
          sum += tmp[k] * tmp[k];
        end
        if (ok && sum < rad * rad && (!found || sum < best)) begin
          found = 1;
          best = sum;
          res = tmp;
        end
      end
      if (found) begin
        rt = root_floor(best[63:0]);
        h.dist_v = rt[30:0];
      end else begin
        h.no_hit = 1;
        h.dist_v = DIST_MAX;
        for (int k = 0; k < 3; k++) res[k] = clip32(off[k]);
      end
    end
    for (int k = 0; k < 3; k++) h.offs[k] = res[k][31:0];
    return h;
  endfunction

  assign pending_o = hit_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sphere_c[0] <= 0;
      sphere_c[1] <= 0;
      sphere_c[2] <= 0;
      sphere_r <= 31'd65536;
      errors_o <= 0;
      hit_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER_X: sphere_c[0] <= cfg_data_i;
          REG_CENTER_Y: sphere_c[1] <= cfg_data_i;
          REG_CENTER_Z: sphere_c[2] <= cfg_data_i;
          REG_RADIUS:   sphere_r <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) hit_q.push_back(predict_hit(vtx_i, nrm_i));
      if (out_valid_i && out_ready_i) begin
        if (hit_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors_o <= errors_o + 1;
        end else begin
          hit_t h;
          int   bad;
          h = hit_q.pop_front();
          bad = 0;
          if (distance_i !== h.dist_v) begin
            $error("distance: expected %0d, got %0d", h.dist_v, distance_i);
            bad++;
          end
          if (offset_x_i !== h.offs[0]) begin
            $error("offset_x: expected %h, got %h", h.offs[0], offset_x_i);
            bad++;
          end
          if (offset_y_i !== h.offs[1]) begin
            $error("offset_y: expected %h, got %h", h.offs[1], offset_y_i);
            bad++;
          end
          if (offset_z_i !== h.offs[2]) begin
            $error("offset_z: expected %h, got %h", h.offs[2], offset_z_i);
            bad++;
          end
          if (inside_res_i !== h.in_tri) begin
            $error("inside_res: expected %0d, got %0d", h.in_tri, inside_res_i);
            bad++;
          end
          if (no_hit_i !== h.no_hit) begin
            $error("no_hit: expected %0d, got %0d", h.no_hit, no_hit_i);
            bad++;
          end
          errors_o <= errors_o + bad;
        end
      end
    end
  end

endmodule

>>> test/tb_sphere_triangle_distance_unit.sv
// Testbench top for the sphere-triangle distance unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_sphere_triangle_distance_unit;
  import sdt_pkg::*;

  localparam int  TRIS_PER_PHASE = 100;
  localparam int  DRAIN_CYCLES   = 90;
  localparam longint CYCLE_LIMIT = 2000000;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_we = 0;
  logic [1:0]         cfg_idx = REG_CENTER_X;
  logic [31:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic signed [31:0] tv [9] = '{default: 0};
  logic signed [15:0] tn [3] = '{default: 0};
  logic               out_valid;
  logic               out_ready = 0;
  logic [30:0]        distance;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic               inside_res;
  logic               no_hit;
  int                 errors;
  int                 pending;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  longint             cycles = 0;
  longint             cen [3] = '{0, 0, 0};

  sphere_triangle_distance_unit uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .a_x_i(tv[0]), .a_y_i(tv[1]), .a_z_i(tv[2]),
    .b_x_i(tv[3]), .b_y_i(tv[4]), .b_z_i(tv[5]),
    .c_x_i(tv[6]), .c_y_i(tv[7]), .c_z_i(tv[8]),
    .norm_x_i(tn[0]), .norm_y_i(tn[1]), .norm_z_i(tn[2]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .distance_o(distance), .offset_x_o(offset_x), .offset_y_o(offset_y),
    .offset_z_o(offset_z), .inside_res_o(inside_res), .no_hit_o(no_hit)
  );

  sdt_result_checker chk (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .vtx_i(tv), .nrm_i(tn),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .distance_i(distance), .offset_x_i(offset_x), .offset_y_i(offset_y),
    .offset_z_i(offset_z), .inside_res_i(inside_res), .no_hit_i(no_hit),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_tri(input longint vv [9], input int nn [3]);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid <= 1;
    for (int k = 0; k < 9; k++) tv[k] <= vv[k];
    for (int k = 0; k < 3; k++) tn[k] <= nn[k];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_sphere(input longint x, input longint y, input longint z,
                            input logic [30:0] r);
    drain();
    write_reg(REG_CENTER_X, x[31:0]);
    write_reg(REG_CENTER_Y, y[31:0]);
    write_reg(REG_CENTER_Z, z[31:0]);
    write_reg(REG_RADIUS, {1'b0, r});
    cfg_we <= 0;
    cen[0] = longint'($signed(x[31:0]));
    cen[1] = longint'($signed(y[31:0]));
    cen[2] = longint'($signed(z[31:0]));
  endtask

  function automatic longint clip(input longint x);
    if (x > 2147483647) return 2147483647;
    if (x < -2147483648) return -2147483648;
    return x;
  endfunction

  // triangle near the sphere center with a matching unit normal
  task automatic good_tri(output longint vv [9], output int nn [3]);
    int  sh;
    real e1 [3];
    real e2 [3];
    real cr [3];
    real len;
    sh = $urandom_range(8, 22);
    for (int k = 0; k < 9; k++)
      vv[k] = clip(cen[k % 3] + longint'($signed($urandom) >>> (31 - sh)));
    for (int k = 0; k < 3; k++) begin
      e1[k] = $itor(vv[3 + k] - vv[k]);
      e2[k] = $itor(vv[6 + k] - vv[k]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    len = $sqrt(cr[0] * cr[0] + cr[1] * cr[1] + cr[2] * cr[2]);
    for (int k = 0; k < 3; k++)
      nn[k] = (len == 0.0) ? $signed(16'($urandom)) : $rtoi(cr[k] / len * 16384.0);
  endtask

  task automatic random_phase();
    longint vv [9];
    int     nn [3];
    int     pick;
    for (int n = 0; n < TRIS_PER_PHASE; n++) begin
      pick = $urandom_range(99);
      good_tri(vv, nn);
      if (pick < 12) begin
        for (int k = 0; k < 9; k++) vv[k] = $signed($urandom);
        for (int k = 0; k < 3; k++) nn[k] = $signed(16'($urandom));
      end else if (pick < 22) begin
        for (int k = 0; k < 3; k++) nn[k] = $signed(16'($urandom));
      end else if (pick < 30) begin
        for (int k = 0; k < 3; k++) vv[3 + k] = vv[k];
      end
      send_tri(vv, nn);
    end
  endtask

  task automatic directed();
    int q;
    q = 65536;
    send_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0});
    send_tri('{default: 2147483647}, '{32767, 32767, 32767});
    send_tri('{default: -2147483648}, '{-32768, -32768, -32768});
    send_tri('{-q, -q, q / 2, q, -q, q / 2, 0, q, q / 2}, '{0, 0, 16384});
    send_tri('{-q, -q, -q / 4, q, -q, -q / 4, 0, q, -q / 4}, '{0, 0, -16384});
    send_tri('{q / 4, -q, 0, 3 * q, -q, 0, q, q, 0}, '{0, 0, 16384});
    send_tri('{10 * q, -q, 0, 12 * q, -q, 0, 11 * q, q, 0}, '{0, 0, 16384});
    send_tri('{-q, 0, -q, q, 0, -q, 0, 0, q}, '{9459, 9459, 9459});
    send_tri('{q / 2, -q, -q, q / 2, q, -q, q / 2, 0, q}, '{5000, 11585, 11585});
    send_tri('{-q, q / 2, 0, q, q / 2, 0, 0, q / 2, q}, '{0, 16384, 0});
    send_tri('{q / 3, q / 3, q / 3, q / 3, q / 3, q / 3, 2 * q, 0, 0}, '{0, 0, 16384});
    send_tri('{q / 2, q / 2, q / 2, q / 2, q / 2, q / 2, q / 2, q / 2, q / 2},
             '{16384, 0, 0});
    send_tri('{default: 32'shAAAAAAAA}, '{-21846, -21846, -21846});
    send_tri('{default: 32'sh55555555}, '{21845, 21845, 21845});
    send_tri('{-q, -q, 2 * q, q, -q, 2 * q, 0, q, 2 * q}, '{0, 0, 16384});
  endtask

  initial begin
    int mode;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    directed();
    for (int ph = 0; ph < 6; ph++) begin
      mode = ph % 4;
      case (ph)
        1: set_sphere($signed($urandom) >>> 9, $signed($urandom) >>> 9,
                      $signed($urandom) >>> 9, 31'h40000);
        2: set_sphere(2147483647, -2147483648, 0, 31'h7FFFFFFF);
        3: set_sphere($signed($urandom), $signed($urandom), $signed($urandom), 31'd0);
        4: set_sphere($signed($urandom) >>> 9, $signed($urandom) >>> 9,
                      $signed($urandom) >>> 9, 31'($urandom_range(1, 1 << 22)));
        5: set_sphere($signed($urandom) >>> 11, $signed($urandom) >>> 11,
                      $signed($urandom) >>> 11, 31'h7FFFFFFF);
        default: ;
      endcase
      idle_pct = (mode == 1) ? 48 : (mode == 3) ? 33 : 0;
      stall_pct = (mode == 2) ? 48 : (mode == 3) ? 33 : 0;
      random_phase();
    end
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
src/sdt_pkg.sv
src/sdt_div.sv
src/sdt_sqrt.sv
src/sphere_triangle_distance_unit.sv
test/sdt_result_checker.sv
test/tb_sphere_triangle_distance_unit.sv
